// ----- rtl/dual_lru_expert_cache_top_macros.svh -----
// ----------------------------------------------------------------------------
// dual lru expert cache assertion macros
// shared concurrent assertion forms used by the rtl
// ----------------------------------------------------------------------------
`ifndef DUAL_LRU_EXPERT_CACHE_TOP_MACROS_SVH
`define DUAL_LRU_EXPERT_CACHE_TOP_MACROS_SVH

// condition holds in the same cycle as the trigger
`define DLEC_ASSERT_SAME(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("dlec assertion failed");

// condition holds in the cycle after the trigger
`define DLEC_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("dlec assertion failed");

`endif

// ----- rtl/dlec_pkg.sv -----
// ----------------------------------------------------------------------------
// dlec_pkg
// types and command codes of the dual lru expert cache
// ----------------------------------------------------------------------------
`default_nettype none

package dlec_pkg;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_EVICT  = 2'd3;

    localparam int unsigned KEY_W    = 18;
    localparam int unsigned HANDLE_W = 48;
    localparam int unsigned BYTES_W  = 32;
    localparam int unsigned STAMP_W  = 64;
    localparam int unsigned CNT_W    = 32;
    localparam int unsigned CAP_W    = 7;

    typedef struct packed {
        logic [1:0]  command;
        logic        cache_select;
        logic [7:0]  layer_index;
        logic [9:0]  expert_index;
        logic [47:0] buffer_handle;
        logic [31:0] size_bytes;
        logic [5:0]  evict_count;
    } item_t;

    typedef struct packed {
        logic        ok;
        logic [47:0] found_handle;
        logic [31:0] found_size;
        logic [6:0]  entry_count;
        logic [31:0] hit_count;
        logic [31:0] miss_count;
    } result_t;

    typedef struct packed {
        logic                valid;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
        logic [BYTES_W-1:0]  bytes;
        logic [STAMP_W-1:0]  stamp;
    } slot_t;

endpackage

`default_nettype wire

// ----- rtl/dual_lru_expert_cache_top.sv -----
// ----------------------------------------------------------------------------
// dual_lru_expert_cache_top
// two lru caches of expert buffers held in rotating rings of slot cells
// ----------------------------------------------------------------------------
// sequence: a lookup or a load starts with a match pass, which ends a lookup or a
//   present-key load; a new-key load adds a gather pass per eviction and the insert
//   or last retire pass, a refused load with nothing to evict ends after matching,
//   clear needs no pass, evict makes gather passes and a retire pass if it evicts
// throughput: one item at a time, busy until the result strobe, which cannot be stalled
// reset: asynchronous, empties both caches, zeroes clock and counters, capacities 64
`default_nettype none

module dual_lru_expert_cache_top #(
    parameter int unsigned ENTRIES = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire dlec_pkg::item_t   item,
    output logic                   busy,
    output logic                   done,
    output dlec_pkg::result_t      result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    `include "dual_lru_expert_cache_top_macros.svh"

    localparam int unsigned IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW   = $clog2(ENTRIES + 1);
    localparam int unsigned CMPW = (CW > dlec_pkg::CAP_W) ? CW : dlec_pkg::CAP_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EVAL = 3'd1;
    localparam logic [2:0] ST_PASS = 3'd2;
    localparam logic [2:0] ST_POST = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    localparam logic [2:0] PH_NONE   = 3'd0;
    localparam logic [2:0] PH_MATCH  = 3'd1;
    localparam logic [2:0] PH_GATHER = 3'd2;
    localparam logic [2:0] PH_INSERT = 3'd3;
    localparam logic [2:0] PH_KILL   = 3'd4;

    logic [2:0]                   state_reg;
    logic [2:0]                   phase_reg;
    logic [IW-1:0]                k_reg;
    logic                         found_reg;
    logic                         pending_reg;
    logic [IW-1:0]                victim_reg;
    logic [IW-1:0]                lru_reg;
    logic [dlec_pkg::STAMP_W-1:0] best_reg;
    logic [dlec_pkg::STAMP_W-1:0] clock_reg;
    logic [dlec_pkg::CNT_W-1:0]   hit_reg [2];
    logic [dlec_pkg::CNT_W-1:0]   miss_reg [2];
    logic [CW-1:0]                count_reg [2];
    logic [dlec_pkg::CAP_W-1:0]   cap0_reg;
    logic [dlec_pkg::CAP_W-1:0]   cap1_reg;
    logic [5:0]                   tries_reg;
    logic                         ok_reg;
    logic                         done_reg;
    dlec_pkg::item_t              item_reg;
    logic [dlec_pkg::HANDLE_W-1:0] fh_reg;
    logic [dlec_pkg::BYTES_W-1:0] fs_reg;
    dlec_pkg::result_t            result_reg;

    dlec_pkg::slot_t              head0;
    dlec_pkg::slot_t              head1;
    dlec_pkg::slot_t              head;
    dlec_pkg::slot_t              wb;
    logic                         sel;
    logic                         kill;
    logic                         live;
    logic [dlec_pkg::KEY_W-1:0]   key_in;
    logic                         match_here;
    logic                         insert_here;
    logic                         older;
    logic [dlec_pkg::STAMP_W-1:0] clock_plus;
    logic [CMPW-1:0]              cap_raw;
    logic [CMPW-1:0]              cap_eff;
    logic [CMPW-1:0]              count_ext;
    logic                         at_cap;
    logic                         need_drop;
    logic                         last_k;
    logic                         accept;
    logic                         cfg_wr;
    logic                         shift0;
    logic                         shift1;
    logic                         clr0;
    logic                         clr1;

    // cache rings
    dlec_ring #(.ENTRIES(ENTRIES)) u_ring0 (
        .clk(clk), .rst_n(rst_n), .shift(shift0), .clr(clr0), .wb(wb), .head(head0)
    );
    dlec_ring #(.ENTRIES(ENTRIES)) u_ring1 (
        .clk(clk), .rst_n(rst_n), .shift(shift1), .clr(clr1), .wb(wb), .head(head1)
    );

    assign sel    = item_reg.cache_select;
    assign shift0 = (state_reg == ST_PASS) && !sel;
    assign shift1 = (state_reg == ST_PASS) && sel;
    assign clr0   = (state_reg == ST_EVAL) && (item_reg.command == dlec_pkg::CMD_CLEAR) && !sel;
    assign clr1   = (state_reg == ST_EVAL) && (item_reg.command == dlec_pkg::CMD_CLEAR) && sel;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);
    assign last_k = (k_reg == IW'(ENTRIES - 1));
    assign key_in = {item_reg.layer_index, item_reg.expert_index};
    assign clock_plus = clock_reg + 64'd1;

    // effective capacity and fill compare
    always_comb
    begin
        cap_raw   = CMPW'(sel ? cap1_reg : cap0_reg);
        cap_eff   = (cap_raw > CMPW'(ENTRIES)) ? CMPW'(ENTRIES) : cap_raw;
        count_ext = CMPW'(count_reg[sel]);
        at_cap    = (count_ext >= cap_eff);
        need_drop = at_cap && (count_ext != '0)
                    && ((item_reg.command == dlec_pkg::CMD_LOAD) || (tries_reg != 6'd0));
    end

    // head slot inspection and write-back
    always_comb
    begin
        head        = sel ? head1 : head0;
        kill        = pending_reg && (k_reg == victim_reg);
        live        = head.valid && !kill;
        match_here  = (phase_reg == PH_MATCH) && live && (head.key == key_in) && !found_reg;
        insert_here = (phase_reg == PH_INSERT) && !live && !found_reg;
        older       = (phase_reg == PH_GATHER) && live
                      && (!found_reg || (head.stamp < best_reg));
        wb          = head;
        wb.valid    = live;
        if (match_here)
        begin
            wb.stamp = clock_plus;
            if (item_reg.command == dlec_pkg::CMD_LOAD)
            begin
                wb.handle = item_reg.buffer_handle;
                wb.bytes  = item_reg.size_bytes;
            end
        end
        if (insert_here)
        begin
            wb = '{valid: 1'b1, key: key_in, handle: item_reg.buffer_handle,
                   bytes: item_reg.size_bytes, stamp: clock_plus};
        end
    end

    // configuration port
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'(cap1_reg) : 32'(cap0_reg);

    // sequencer and cache bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_NONE;
            k_reg       <= '0;
            found_reg   <= 1'b0;
            pending_reg <= 1'b0;
            victim_reg  <= '0;
            clock_reg   <= '0;
            hit_reg[0]  <= '0;
            hit_reg[1]  <= '0;
            miss_reg[0] <= '0;
            miss_reg[1] <= '0;
            count_reg[0] <= '0;
            count_reg[1] <= '0;
            cap0_reg    <= 7'd64;
            cap1_reg    <= 7'd64;
            tries_reg   <= '0;
            ok_reg      <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == ST_OUT);
            if (cfg_wr)
            begin
                if (paddr[2])
                begin
                    cap1_reg <= pwdata[dlec_pkg::CAP_W-1:0];
                end
                else
                begin
                    cap0_reg <= pwdata[dlec_pkg::CAP_W-1:0];
                end
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg   <= ST_EVAL;
                        phase_reg   <= PH_NONE;
                        pending_reg <= 1'b0;
                        ok_reg      <= 1'b0;
                        tries_reg   <= item.evict_count;
                    end
                end
                ST_EVAL:
                begin
                    k_reg     <= '0;
                    found_reg <= 1'b0;
                    if (item_reg.command == dlec_pkg::CMD_CLEAR)
                    begin
                        count_reg[sel] <= '0;
                        state_reg      <= ST_OUT;
                    end
                    else if (phase_reg == PH_NONE && item_reg.command != dlec_pkg::CMD_EVICT)
                    begin
                        phase_reg <= PH_MATCH;
                        state_reg <= ST_PASS;
                    end
                    else if (need_drop)
                    begin
                        phase_reg <= PH_GATHER;
                        state_reg <= ST_PASS;
                    end
                    else if (item_reg.command == dlec_pkg::CMD_LOAD && !at_cap)
                    begin
                        phase_reg <= PH_INSERT;
                        state_reg <= ST_PASS;
                    end
                    else if (pending_reg)
                    begin
                        phase_reg <= PH_KILL;
                        state_reg <= ST_PASS;
                    end
                    else
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_PASS:
                begin
                    if (match_here || insert_here || older)
                    begin
                        found_reg <= 1'b1;
                    end
                    k_reg <= k_reg + IW'(1);
                    if (last_k)
                    begin
                        state_reg <= ST_POST;
                    end
                end
                ST_POST:
                begin
                    case (phase_reg)
                        PH_MATCH:
                        begin
                            if (item_reg.command == dlec_pkg::CMD_LOOKUP)
                            begin
                                state_reg <= ST_OUT;
                                if (found_reg)
                                begin
                                    ok_reg    <= 1'b1;
                                    clock_reg <= clock_plus;
                                    if (hit_reg[sel] != '1)
                                    begin
                                        hit_reg[sel] <= hit_reg[sel] + 32'd1;
                                    end
                                end
                                else if (miss_reg[sel] != '1)
                                begin
                                    miss_reg[sel] <= miss_reg[sel] + 32'd1;
                                end
                            end
                            else if (found_reg)
                            begin
                                ok_reg    <= 1'b1;
                                clock_reg <= clock_plus;
                                state_reg <= ST_OUT;
                            end
                            else
                            begin
                                state_reg <= ST_EVAL;
                            end
                        end
                        PH_GATHER:
                        begin
                            pending_reg    <= 1'b1;
                            victim_reg     <= lru_reg;
                            count_reg[sel] <= count_reg[sel] - CW'(1);
                            tries_reg      <= tries_reg - 6'd1;
                            state_reg      <= ST_EVAL;
                        end
                        PH_INSERT:
                        begin
                            pending_reg    <= 1'b0;
                            ok_reg         <= 1'b1;
                            clock_reg      <= clock_plus;
                            count_reg[sel] <= count_reg[sel] + CW'(1);
                            state_reg      <= ST_OUT;
                        end
                        default:
                        begin
                            pending_reg <= 1'b0;
                            state_reg   <= ST_OUT;
                        end
                    endcase
                end
                ST_OUT:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // item beat, lru tracking, lookup data and result beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
            fh_reg   <= '0;
            fs_reg   <= '0;
        end
        if (state_reg == ST_PASS)
        begin
            if (older)
            begin
                best_reg <= head.stamp;
                lru_reg  <= k_reg;
            end
            if (match_here && item_reg.command == dlec_pkg::CMD_LOOKUP)
            begin
                fh_reg <= head.handle;
                fs_reg <= head.bytes;
            end
        end
        if (state_reg == ST_OUT)
        begin
            result_reg.ok           <= ok_reg;
            result_reg.found_handle <= fh_reg;
            result_reg.found_size   <= fs_reg;
            result_reg.entry_count  <= count_ext[6:0];
            result_reg.hit_count    <= hit_reg[sel];
            result_reg.miss_count   <= miss_reg[sel];
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // checks
    `DLEC_ASSERT_NEXT(a_done_after_out, clk, rst_n, state_reg == ST_OUT, done)
    `DLEC_ASSERT_SAME(a_done_idle, clk, rst_n, done, !busy)
    `DLEC_ASSERT_NEXT(a_accept_eval, clk, rst_n, accept, state_reg == ST_EVAL)
    `DLEC_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1,
        (count_reg[0] <= CW'(ENTRIES)) && (count_reg[1] <= CW'(ENTRIES)))

endmodule

`default_nettype wire

// ----- rtl/dlec_cell.sv -----
// ----------------------------------------------------------------------------
// dlec_cell
// one cache slot of the ring, takes its neighbor's slot on every shift
// ----------------------------------------------------------------------------
`default_nettype none

module dlec_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            shift,
    input  wire logic            clr,
    input  wire dlec_pkg::slot_t nxt,
    output dlec_pkg::slot_t      cur
);

    logic                          valid_reg;
    logic [dlec_pkg::KEY_W-1:0]    key_reg;
    logic [dlec_pkg::HANDLE_W-1:0] handle_reg;
    logic [dlec_pkg::BYTES_W-1:0]  bytes_reg;
    logic [dlec_pkg::STAMP_W-1:0]  stamp_reg;

    // valid bit, cleared by reset or a clear command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (clr)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= nxt.valid;
        end
    end

    // slot payload
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            key_reg    <= nxt.key;
            handle_reg <= nxt.handle;
            bytes_reg  <= nxt.bytes;
            stamp_reg  <= nxt.stamp;
        end
    end

    assign cur = '{valid: valid_reg, key: key_reg, handle: handle_reg,
                   bytes: bytes_reg, stamp: stamp_reg};

endmodule

`default_nettype wire

// ----- rtl/dlec_ring.sv -----
// ----------------------------------------------------------------------------
// dlec_ring
// ring of slot cells for one cache, slot k sits at the head after k shifts
// ----------------------------------------------------------------------------
`default_nettype none

module dlec_ring #(
    parameter int unsigned ENTRIES = 64
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            shift,
    input  wire logic            clr,
    input  wire dlec_pkg::slot_t wb,
    output dlec_pkg::slot_t      head
);

    dlec_pkg::slot_t cur [ENTRIES];

    // each cell takes its upper neighbor, the last one takes the write-back slot
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        dlec_pkg::slot_t nxt;
        if (i == ENTRIES - 1)
        begin : g_last
            assign nxt = wb;
        end
        else
        begin : g_mid
            assign nxt = cur[i+1];
        end
        dlec_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (shift),
            .clr   (clr),
            .nxt   (nxt),
            .cur   (cur[i])
        );
    end

    assign head = cur[0];

endmodule

`default_nettype wire
